@@ hdl/lcdr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdr_pkg
// Shared types and constants of the character LCD refresh controller.
// ----------------------------------------------------------------------------
package lcdr_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FUNCTION_SET    = 3'd0,
    CFG_DISPLAY_CONTROL = 3'd1,
    CFG_ENTRY_MODE      = 3'd2,
    CFG_SETTLE_WAIT     = 3'd3,
    CFG_POWER_UP_WAIT   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  CMD_CLEAR           = 8'h01;
  localparam logic [7:0]  CMD_SET_ADDR        = 8'h80;
  localparam logic [7:0]  ROW1_OFFSET         = 8'h40;
  localparam logic [7:0]  CHAR_SPACE          = 8'h20;
  localparam logic [15:0] HIGH_NIBBLE_WAIT_US = 16'd4;

  localparam logic [7:0]  RST_FUNCTION_SET    = 8'h2A;
  localparam logic [7:0]  RST_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0]  RST_ENTRY_MODE      = 8'h06;
  localparam logic [15:0] RST_SETTLE_WAIT     = 16'd80;
  localparam logic [15:0] RST_POWER_UP_WAIT   = 16'd40000;

  // bus step sequencing
  localparam logic [3:0] STEP_INIT_WAKE0    = 4'd1;  // first "3" nibble
  localparam logic [3:0] STEP_INIT_WAKE_END = 4'd4;  // the "2" nibble
  localparam logic [3:0] STEP_INIT_BYTES    = 4'd5;  // first set-up byte
  localparam logic [3:0] STEP_INIT_LAST     = 4'd14;
  localparam logic [3:0] STEP_TICK_CHAR     = 4'd2;
  localparam logic [3:0] STEP_TICK_LAST     = 4'd3;
  localparam logic [3:0] WAKE_NIBBLE        = 4'd3;
  localparam logic [3:0] FOUR_BIT_NIBBLE    = 4'd2;

  typedef struct packed {
    logic [7:0]  function_set;
    logic [7:0]  display_control;
    logic [7:0]  entry_mode;
    logic [15:0] settle_wait;
    logic [15:0] power_up_wait;
  } cfg_t;

  // one classified job handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       row;
    logic       col_zero;
    logic [7:0] char_code;
  } cmd_t;

endpackage

@@ hdl/lcdr_ram.sv @@
// ----------------------------------------------------------------------------
// lcdr_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lcdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lcdr_front.sv @@
// ----------------------------------------------------------------------------
// lcdr_front
// Accepts items, keeps the frame buffer and refresh position, and hands
// init and tick jobs to the queue.
// ----------------------------------------------------------------------------
module lcdr_front #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_kind_i,
  input  logic              in_row_i,
  input  logic [3:0]        in_col_i,
  input  logic [7:0]        in_char_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output lcdr_pkg::cmd_t    q_data_o
);

  localparam int unsigned Depth = 2 * COLUMNS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(COLUMNS);

  logic          accept, do_init, do_tick, do_write, col_ok;
  logic [AW:0]   wr_sum, rd_sum;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rdata;

  logic [Depth-1:0] valid_q, valid_d;
  logic             row_q, row_d;
  logic [CW-1:0]    col_q, col_d;

  logic s1_valid_q, s1_valid_d;
  logic s1_init_q, s1_row_q, s1_col0_q, s1_cvalid_q;

  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign do_init    = accept && (in_kind_i == lcdr_pkg::KIND_INIT);
  assign do_tick    = accept && (in_kind_i == lcdr_pkg::KIND_TICK);

  assign wr_sum   = (AW+1)'(in_col_i) + (in_row_i ? (AW+1)'(COLUMNS) : '0);
  assign col_ok   = (AW+1)'(in_col_i) < (AW+1)'(COLUMNS);
  assign do_write = accept && (in_kind_i == lcdr_pkg::KIND_WRITE) && col_ok;
  assign wr_addr  = wr_sum[AW-1:0];

  assign rd_sum  = (AW+1)'(col_q) + (row_q ? (AW+1)'(COLUMNS) : '0);
  assign rd_addr = rd_sum[AW-1:0];

  lcdr_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_addr),
    .wdata_i (in_char_i),
    .re_i    (do_tick),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (do_write) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (do_init) begin
      row_d = 1'b0;
      col_d = '0;
    end else if (do_tick) begin
      if (col_q == CW'(COLUMNS - 1)) begin
        col_d = '0;
        row_d = !row_q;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign q_push_o = s1_valid_q && !q_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (do_init || do_tick) begin
      s1_valid_d = 1'b1;
    end else if (q_push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      row_q      <= 1'b0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_init || do_tick) begin
      s1_init_q   <= do_init;
      s1_row_q    <= row_q;
      s1_col0_q   <= (col_q == '0);
      s1_cvalid_q <= valid_q[rd_addr];
    end
  end

  // never-written entries read as space
  always_comb begin
    q_data_o.is_init   = s1_init_q;
    q_data_o.row       = s1_row_q;
    q_data_o.col_zero  = s1_col0_q;
    q_data_o.char_code = s1_cvalid_q ? rdata : lcdr_pkg::CHAR_SPACE;
  end

endmodule

@@ hdl/lcdr_queue.sv @@
// ----------------------------------------------------------------------------
// lcdr_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module lcdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcdr_pkg::cmd_t data_i,
  input  logic           pop_i,
  output lcdr_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned NW    = $clog2(Depth + 1);

  lcdr_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [NW-1:0]  cnt_q;

  assign full_o  = (cnt_q == NW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

@@ hdl/lcdr_back.sv @@
// ----------------------------------------------------------------------------
// lcdr_back
// Expands queued jobs into bus steps, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module lcdr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcdr_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  lcdr_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_rs_o,
  output logic [3:0]     out_nibble_o,
  output logic           out_pulse_o,
  output logic [15:0]    out_wait_o,
  output logic           out_last_o
);

  lcdr_pkg::cmd_t cur_q;
  logic           cur_valid_q;
  logic [3:0]     step_q;

  logic        emit, step_last;
  logic        s_rs, s_pulse, s_low, s_use_byte;
  logic [3:0]  s_nib;
  logic [15:0] s_wait;
  logic [7:0]  s_byte;
  logic [3:0]  idx;

  logic        out_valid_q, out_rs_q, out_pulse_q, out_last_q;
  logic [3:0]  out_nib_q;
  logic [15:0] out_wait_q;

  assign idx = step_q - lcdr_pkg::STEP_INIT_BYTES;

  always_comb begin
    s_rs       = 1'b0;
    s_pulse    = 1'b1;
    s_nib      = '0;
    s_wait     = cfg_i.settle_wait;
    s_byte     = '0;
    s_low      = step_q[0];
    s_use_byte = 1'b1;
    step_last  = 1'b0;
    if (cur_q.is_init) begin
      step_last = (step_q == lcdr_pkg::STEP_INIT_LAST);
      s_low     = idx[0];
      if (step_q < lcdr_pkg::STEP_INIT_WAKE0) begin
        s_use_byte = 1'b0;
        s_pulse    = 1'b0;
        s_wait     = cfg_i.power_up_wait;
      end else if (step_q <= lcdr_pkg::STEP_INIT_WAKE_END) begin
        s_use_byte = 1'b0;
        s_nib      = (step_q == lcdr_pkg::STEP_INIT_WAKE_END) ?
                     lcdr_pkg::FOUR_BIT_NIBBLE : lcdr_pkg::WAKE_NIBBLE;
      end else begin
        case (idx[3:1])
          3'd0:    s_byte = cfg_i.function_set;
          3'd1:    s_byte = cfg_i.display_control;
          3'd2:    s_byte = lcdr_pkg::CMD_CLEAR;
          3'd3:    s_byte = cfg_i.entry_mode;
          default: s_byte = lcdr_pkg::CMD_SET_ADDR;
        endcase
      end
    end else begin
      step_last = (step_q == lcdr_pkg::STEP_TICK_LAST);
      if (step_q < lcdr_pkg::STEP_TICK_CHAR) begin
        s_byte = lcdr_pkg::CMD_SET_ADDR | (cur_q.row ? lcdr_pkg::ROW1_OFFSET : 8'h00);
      end else begin
        s_rs   = 1'b1;
        s_byte = cur_q.char_code;
      end
    end
    if (s_use_byte) begin
      s_nib  = s_low ? s_byte[3:0] : s_byte[7:4];
      s_wait = s_low ? cfg_i.settle_wait : lcdr_pkg::HIGH_NIBBLE_WAIT_US;
    end
  end

  assign emit    = cur_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = !q_empty_i && (!cur_valid_q || (emit && step_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        step_q      <= (q_head_i.is_init || q_head_i.col_zero) ? 4'd0
                                                               : lcdr_pkg::STEP_TICK_CHAR;
      end else if (emit && step_last) begin
        cur_valid_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 4'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (emit) begin
      out_rs_q    <= s_rs;
      out_nib_q   <= s_nib;
      out_pulse_q <= s_pulse;
      out_wait_q  <= s_wait;
      out_last_q  <= step_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_rs_o     = out_rs_q;
  assign out_nibble_o = out_nib_q;
  assign out_pulse_o  = out_pulse_q;
  assign out_wait_o   = out_wait_q;
  assign out_last_o   = out_last_q;

endmodule

@@ hdl/char_lcd_nibble_refresh_controller_core.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_refresh_controller_core
// Two-line character LCD controller for a 4-bit bus with a frame buffer.
// ----------------------------------------------------------------------------
// An input item is an init, a character write or a refresh tick; each result
// is one bus step (nibble, register select, enable pulse flag, wait in us),
// with tlast on the final step of the item. Writes and ignored kinds are
// accepted at the input and give nothing. Ticks give 2 steps (4 at column 0),
// init gives 15; the step sequencer emits one step per clock while the output
// is not stalled, and the queue lets new items in until it is full. The
// first step passes the frame buffer read, the queue, the job register and the
// output register. The frame buffer reads as spaces from reset with no clearing
// pass; init keeps its contents and only rewinds the refresh position.
// The user must write configuration only while the block is idle (unchecked).
module char_lcd_nibble_refresh_controller_core #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcdr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // row, col[3:0], char_code[7:0]
  input  logic [1:0]                    s_axis_tuser_i,  // kind[1:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [23:0]                   m_axis_tdata_o,  // nibble[3:0], pulse, wait_us[15:0]
  output logic                          m_axis_tuser_o,  // reg_select
  output logic                          m_axis_tlast_o
);

  lcdr_pkg::cfg_t cfg_q;
  lcdr_pkg::cmd_t push_data, head;
  logic           push, pop, q_full, q_empty;
  logic           o_pulse;
  logic [3:0]     o_nib;
  logic [15:0]    o_wait;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set    <= lcdr_pkg::RST_FUNCTION_SET;
      cfg_q.display_control <= lcdr_pkg::RST_DISPLAY_CONTROL;
      cfg_q.entry_mode      <= lcdr_pkg::RST_ENTRY_MODE;
      cfg_q.settle_wait     <= lcdr_pkg::RST_SETTLE_WAIT;
      cfg_q.power_up_wait   <= lcdr_pkg::RST_POWER_UP_WAIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdr_pkg::CFG_FUNCTION_SET:    cfg_q.function_set    <= cfg_wdata_i[7:0];
        lcdr_pkg::CFG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_wdata_i[7:0];
        lcdr_pkg::CFG_ENTRY_MODE:      cfg_q.entry_mode      <= cfg_wdata_i[7:0];
        lcdr_pkg::CFG_SETTLE_WAIT:     cfg_q.settle_wait     <= cfg_wdata_i;
        lcdr_pkg::CFG_POWER_UP_WAIT:   cfg_q.power_up_wait   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lcdr_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_row_i   (s_axis_tdata_i[0]),
    .in_col_i   (s_axis_tdata_i[4:1]),
    .in_char_i  (s_axis_tdata_i[12:5]),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  lcdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lcdr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_head_i     (head),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_rs_o     (m_axis_tuser_o),
    .out_nibble_o (o_nib),
    .out_pulse_o  (o_pulse),
    .out_wait_o   (o_wait),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, o_wait, o_pulse, o_nib};

endmodule

@@ tb/char_lcd_nibble_refresh_controller_core_tb.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_refresh_controller_core_tb
// Self-checking bench for the character LCD refresh controller: items go in
// on the slave stream, every bus step coming out is checked against a local
// model of the frame buffer, refresh position and init sequence.
// ----------------------------------------------------------------------------
module char_lcd_nibble_refresh_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMNS      = 16;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic       row;
    logic [3:0] col;
    logic [7:0] char_code;
  } lcd_item_t;

  typedef struct {
    logic        reg_select;
    logic [3:0]  nibble;
    logic        pulse;
    logic [15:0] wait_us;
    logic        last;
  } bus_step_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lcdr_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lcdr_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [15:0]                   s_axis_tdata_i;   // row, col[3:0], char_code[7:0]
  logic [1:0]                    s_axis_tuser_i;   // kind[1:0]
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [23:0]                   m_axis_tdata_o;   // nibble[3:0], pulse, wait_us[15:0]
  logic                          m_axis_tuser_o;   // reg_select
  logic                          m_axis_tlast_o;

  char_lcd_nibble_refresh_controller_core #(
    .COLUMNS(COLUMNS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // model state
  logic [7:0]     frame_buf [2*COLUMNS];
  logic           refresh_row;
  int unsigned    refresh_col;
  lcdr_pkg::cfg_t cfg_model;

  bus_step_t   exp_steps[$];
  bus_step_t   new_steps[$];
  int unsigned mismatches;
  bit          no_idle;
  bit          sink_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic void add_step(logic rs, logic [3:0] nib, logic pulse, logic [15:0] wt);
    bus_step_t s;
    s.reg_select = rs;
    s.nibble     = nib;
    s.pulse      = pulse;
    s.wait_us    = wt;
    s.last       = 1'b0;
    new_steps.push_back(s);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b);
    add_step(rs, b[7:4], 1'b1, lcdr_pkg::HIGH_NIBBLE_WAIT_US);
    add_step(rs, b[3:0], 1'b1, cfg_model.settle_wait);
  endfunction

  function automatic void lcd_predict(lcd_item_t it);
    int unsigned pos;
    new_steps.delete();
    case (it.kind)
      lcdr_pkg::KIND_INIT: begin
        add_step(1'b0, 4'h0, 1'b0, cfg_model.power_up_wait);
        repeat (3) add_step(1'b0, lcdr_pkg::WAKE_NIBBLE, 1'b1, cfg_model.settle_wait);
        add_step(1'b0, lcdr_pkg::FOUR_BIT_NIBBLE, 1'b1, cfg_model.settle_wait);
        add_byte(1'b0, cfg_model.function_set);
        add_byte(1'b0, cfg_model.display_control);
        add_byte(1'b0, lcdr_pkg::CMD_CLEAR);
        add_byte(1'b0, cfg_model.entry_mode);
        add_byte(1'b0, lcdr_pkg::CMD_SET_ADDR);
        refresh_row = 1'b0;
        refresh_col = 0;
      end
      lcdr_pkg::KIND_WRITE: begin
        if (int'(it.col) < COLUMNS) begin
          frame_buf[int'(it.row) * COLUMNS + int'(it.col)] = it.char_code;
        end
      end
      lcdr_pkg::KIND_TICK: begin
        pos = int'(refresh_row) * COLUMNS + refresh_col;
        if (refresh_col == 0) begin
          add_byte(1'b0, lcdr_pkg::CMD_SET_ADDR |
                         (refresh_row ? lcdr_pkg::ROW1_OFFSET : 8'h00));
        end
        add_byte(1'b1, frame_buf[pos]);
        if (refresh_col == COLUMNS - 1) begin
          refresh_col = 0;
          refresh_row = ~refresh_row;
        end else begin
          refresh_col++;
        end
      end
      default: ;  // unused kind: no effect
    endcase
    if (new_steps.size() != 0) new_steps[new_steps.size() - 1].last = 1'b1;
    foreach (new_steps[i]) exp_steps.push_back(new_steps[i]);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] kind, logic row, logic [3:0] col, logic [7:0] ch);
    lcd_item_t it;
    it.kind      = kind;
    it.row       = row;
    it.col       = col;
    it.char_code = ch;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, ch, col, row};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lcd_predict(it);
  endtask

  // drop valid, then let every pending step come out before touching config
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (exp_steps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(int unsigned idx, logic [lcdr_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx[lcdr_pkg::CfgIdxW-1:0];
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      lcdr_pkg::CFG_FUNCTION_SET:    cfg_model.function_set    = data[7:0];
      lcdr_pkg::CFG_DISPLAY_CONTROL: cfg_model.display_control = data[7:0];
      lcdr_pkg::CFG_ENTRY_MODE:      cfg_model.entry_mode      = data[7:0];
      lcdr_pkg::CFG_SETTLE_WAIT:     cfg_model.settle_wait     = data;
      lcdr_pkg::CFG_POWER_UP_WAIT:   cfg_model.power_up_wait   = data;
      default: ;
    endcase
  endtask

  task automatic cfg_write_all(logic [lcdr_pkg::CfgDataW-1:0] cmd_val,
                               logic [lcdr_pkg::CfgDataW-1:0] wait_val,
                               logic [lcdr_pkg::CfgDataW-1:0] junk_val);
    cfg_write(lcdr_pkg::CFG_FUNCTION_SET, cmd_val);
    cfg_write(lcdr_pkg::CFG_DISPLAY_CONTROL, cmd_val);
    cfg_write(lcdr_pkg::CFG_ENTRY_MODE, cmd_val);
    cfg_write(lcdr_pkg::CFG_SETTLE_WAIT, wait_val);
    cfg_write(lcdr_pkg::CFG_POWER_UP_WAIT, wait_val);
    // indexes past the register list must not disturb anything
    for (int i = int'(lcdr_pkg::CFG_POWER_UP_WAIT) + 1; i < (1 << lcdr_pkg::CfgIdxW); i++)
      cfg_write(i, junk_val);
  endtask

  task automatic cfg_randomize();
    cfg_write(lcdr_pkg::CFG_FUNCTION_SET, 16'($urandom_range(0, 65535)));
    cfg_write(lcdr_pkg::CFG_DISPLAY_CONTROL, 16'($urandom_range(0, 65535)));
    cfg_write(lcdr_pkg::CFG_ENTRY_MODE, 16'($urandom_range(0, 65535)));
    cfg_write(lcdr_pkg::CFG_SETTLE_WAIT, 16'($urandom_range(0, 65535)));
    cfg_write(lcdr_pkg::CFG_POWER_UP_WAIT, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  ch;
    logic        row;
    logic [3:0]  col;
    pick = $urandom_range(0, 99);
    ch   = ($urandom_range(0, 7) == 0) ? {8{pick[0]}} : 8'($urandom_range(0, 255));
    row  = 1'($urandom_range(0, 1));
    col  = 4'($urandom_range(0, 15));
    if (pick < 7)       send_item(lcdr_pkg::KIND_INIT, row, col, ch);
    else if (pick < 11) send_item(KIND_UNUSED, row, col, ch);
    else if (pick < 45) send_item(lcdr_pkg::KIND_WRITE, row, col, ch);
    else                send_item(lcdr_pkg::KIND_TICK, row, col, ch);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // space from reset, then writes at the corners and an ignored kind
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_INIT, 1'b1, 4'hF, 8'hFF);
    send_item(lcdr_pkg::KIND_WRITE, 1'b0, 4'h0, 8'hFF);
    send_item(lcdr_pkg::KIND_WRITE, 1'b1, 4'hF, 8'h00);
    send_item(lcdr_pkg::KIND_WRITE, 1'b0, 4'h1, 8'hA5);
    send_item(KIND_UNUSED, 1'b0, 4'h1, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b1, 4'hF, 8'hFF);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    // init rewinds the position, buffer stays
    send_item(lcdr_pkg::KIND_INIT, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    cfg_write_all(16'h0000, 16'h0000, 16'hFFFF);
    send_item(lcdr_pkg::KIND_INIT, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    wait_drained();
    cfg_write_all(16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(lcdr_pkg::KIND_INIT, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    wait_drained();
  endtask

  // fill a few cells, then refresh past the end of the screen so both rows
  // and the wrap back to row 0 column 0 are seen
  task automatic test_screen_sweep();
    send_item(lcdr_pkg::KIND_INIT, 1'b0, 4'h0, 8'h00);
    repeat (8) send_item(lcdr_pkg::KIND_WRITE, 1'($urandom_range(0, 1)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    repeat (2 * COLUMNS + 2) send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n);
    cfg_randomize();
    repeat (n) send_random_item();
    wait_drained();
  endtask

  task automatic test_backpressure();
    bit saved;
    saved         = no_idle;
    no_idle       = 1'b1;
    sink_hold_req = 1'b1;
    repeat (30) send_item(lcdr_pkg::KIND_TICK, 1'b0, 4'h0, 8'h00);
    send_item(lcdr_pkg::KIND_INIT, 1'b0, 4'h0, 8'h00);
    no_idle = saved;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sink ready: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_ready
    int unsigned n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        n = 1;
        while (n < HOLD_CYCLES) begin
          @(negedge clk_i);
          n++;
        end
        sink_hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    bus_step_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_steps.size() == 0) begin
        $error("bus step with no item pending: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        e = exp_steps.pop_front();
        check_field("reg_select", 32'(e.reg_select), 32'(m_axis_tuser_o));
        check_field("nibble", 32'(e.nibble), 32'(m_axis_tdata_o[3:0]));
        check_field("pulse", 32'(e.pulse), 32'(m_axis_tdata_o[4]));
        check_field("wait_us", 32'(e.wait_us), 32'(m_axis_tdata_o[20:5]));
        check_field("last", 32'(e.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    mismatches      = 0;
    no_idle         = 1'b0;
    sink_hold_req   = 1'b0;
    foreach (frame_buf[i]) frame_buf[i] = lcdr_pkg::CHAR_SPACE;
    refresh_row                = 1'b0;
    refresh_col                = 0;
    cfg_model.function_set     = lcdr_pkg::RST_FUNCTION_SET;
    cfg_model.display_control  = lcdr_pkg::RST_DISPLAY_CONTROL;
    cfg_model.entry_mode       = lcdr_pkg::RST_ENTRY_MODE;
    cfg_model.settle_wait      = lcdr_pkg::RST_SETTLE_WAIT;
    cfg_model.power_up_wait    = lcdr_pkg::RST_POWER_UP_WAIT;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_screen_sweep();
    test_random(45);
    test_backpressure();
    test_random(30);
    no_idle = 1'b1;
    test_random(20);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
